// ----- rtl/core/fflid_pkg.sv -----
package fflid_pkg;

  localparam int POOL_DEPTH = 2048;
  localparam int ID_W       = $clog2(POOL_DEPTH);
  localparam int LINK_W     = $clog2(POOL_DEPTH + 1);
  localparam int REQ_ID_W   = 11;
  localparam int STATUS_W   = 2;

  localparam logic [LINK_W-1:0] LINK_END  = LINK_W'(POOL_DEPTH);
  localparam logic [LINK_W-1:0] TAIL_INIT = LINK_W'(POOL_DEPTH - 1);
  localparam logic [ID_W-1:0]   CLR_LAST  = ID_W'(POOL_DEPTH - 1);

  localparam logic ACT_ALLOC   = 1'b0;
  localparam logic ACT_RELEASE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FREE  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } state_t;

  typedef struct packed {
    logic clr_step;
    logic load;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic out_free;
  } dp_sts_t;

endpackage

// ----- rtl/core/fflid_ctrl.sv -----
module fflid_ctrl
  import fflid_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  dp_sts_t   sts,
  output ctrl_cmd_t cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
      end
      S_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      S_EXEC: begin
        cmd.commit = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ----- rtl/core/fflid_dpath.sv -----
module fflid_dpath
  import fflid_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  ctrl_cmd_t           cmd,
  output dp_sts_t             sts,
  input  logic                in_action,
  input  logic [REQ_ID_W-1:0] in_release_id,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [REQ_ID_W-1:0] out_granted_id,
  output logic [STATUS_W-1:0] out_status
);

  logic [LINK_W-1:0] link_mem [POOL_DEPTH];
  logic              mark_mem [POOL_DEPTH];

  logic [LINK_W-1:0]   head_r, head_nxt;
  logic [LINK_W-1:0]   tail_r, tail_nxt;
  logic [ID_W-1:0]     clr_cnt_r;
  logic                req_act_r;
  logic [REQ_ID_W-1:0] req_id_r;
  logic [LINK_W-1:0]   rd_link_r;
  logic                rd_mark_r;
  logic                out_valid_r;
  logic [REQ_ID_W-1:0] granted_r, granted_nxt;
  status_t             status_r, status_nxt;

  logic [31:0]       in_id_ext, req_id_ext, head_ext;
  logic [ID_W-1:0]   rd_addr;
  logic [ID_W-1:0]   req_addr;
  logic [ID_W-1:0]   head_addr;
  logic [ID_W-1:0]   tail_addr;
  logic              alloc_empty, rel_oor, tail_end, op_ok;
  logic              link_we, mark_we, mark_wd;
  logic [ID_W-1:0]   link_wa, mark_wa;
  logic [LINK_W-1:0] link_wd;

  assign in_id_ext  = 32'(in_release_id);
  assign req_id_ext = 32'(req_id_r);
  assign head_ext   = 32'(head_r);
  assign head_addr  = head_ext[ID_W-1:0];
  assign tail_addr  = tail_r[ID_W-1:0];
  assign req_addr   = req_id_ext[ID_W-1:0];
  assign rd_addr    = (in_action == ACT_RELEASE) ? in_id_ext[ID_W-1:0] : head_addr;

  assign alloc_empty = (head_r == LINK_END);
  assign rel_oor     = (req_id_ext >= 32'(POOL_DEPTH));
  assign tail_end    = (tail_r == LINK_END);

  always_comb begin
    status_nxt  = ST_OK;
    granted_nxt = '0;
    if (req_act_r == ACT_ALLOC) begin
      if (alloc_empty) begin
        status_nxt = ST_EMPTY;
      end else begin
        granted_nxt = head_ext[REQ_ID_W-1:0];
      end
    end else if (rel_oor) begin
      status_nxt = ST_RANGE;
    end else if (rd_mark_r) begin
      status_nxt = ST_FREE;
    end
  end

  assign op_ok = cmd.commit && (status_nxt == ST_OK);

  // a released entry keeps a stale link; it is only followed once a later
  // release has overwritten it, and taking the tail empties the list, so a
  // release writes only the old tail's link
  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    link_we  = 1'b0;
    link_wa  = clr_cnt_r;
    link_wd  = LINK_W'(clr_cnt_r) + LINK_W'(1);
    mark_we  = 1'b0;
    mark_wa  = clr_cnt_r;
    mark_wd  = 1'b1;
    if (cmd.clr_step) begin
      link_we = 1'b1;
      mark_we = 1'b1;
    end else if (op_ok) begin
      mark_we = 1'b1;
      if (req_act_r == ACT_ALLOC) begin
        mark_wa  = head_addr;
        mark_wd  = 1'b0;
        if (head_r == tail_r) begin
          head_nxt = LINK_END;
          tail_nxt = LINK_END;
        end else begin
          head_nxt = rd_link_r;
        end
      end else begin
        mark_wa  = req_addr;
        mark_wd  = 1'b1;
        tail_nxt = LINK_W'(req_id_ext);
        if (tail_end) begin
          head_nxt = LINK_W'(req_id_ext);
        end else begin
          link_we = 1'b1;
          link_wa = tail_addr;
          link_wd = LINK_W'(req_id_ext);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (link_we) link_mem[link_wa] <= link_wd;
    if (mark_we) mark_mem[mark_wa] <= mark_wd;
    if (cmd.load) begin
      rd_link_r <= link_mem[rd_addr];
      rd_mark_r <= mark_mem[rd_addr];
      req_act_r <= in_action;
      req_id_r  <= in_release_id;
    end
    if (cmd.commit) begin
      granted_r <= granted_nxt;
      status_r  <= status_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= TAIL_INIT;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      if (cmd.clr_step) clr_cnt_r <= clr_cnt_r + ID_W'(1);
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.clr_last = (clr_cnt_r == CLR_LAST);
  assign sts.out_free = !out_valid_r || out_ready;

  assign out_valid      = out_valid_r;
  assign out_granted_id = granted_r;
  assign out_status     = status_r;

endmodule

// ----- rtl/core/fifo_free_list_id_allocator_unit.sv -----
// channel | direction | tdata (low bit up)                      | tuser
// in_     | slave     | release_id[10:0], zero pad to 16 bits    | action
// out_    | master    | granted_id[10:0], status[12:11], pad 16  | -
//
// Per item: the accept cycle (S_IDLE) reads the head (or released) entry of
// the link and free-mark memories, then S_EXEC commits and loads the result;
// no new item is taken before that. After reset a clearing pass writes all
// POOL_DEPTH (2048) entries to build the chain; in_tready is low throughout.
// A stalled result holds the block in its commit cycle until out_tready.
module fifo_free_list_id_allocator_unit
  import fflid_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // release_id[10:0]
  input  logic        in_tuser,   // action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // granted_id[10:0], status[12:11]
);

  ctrl_cmd_t           cmd;
  dp_sts_t             sts;
  logic [REQ_ID_W-1:0] granted_id;
  logic [STATUS_W-1:0] status;

  fflid_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  fflid_dpath u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_action      (in_tuser),
    .in_release_id  (in_tdata[REQ_ID_W-1:0]),
    .out_valid      (out_tvalid),
    .out_ready      (out_tready),
    .out_granted_id (granted_id),
    .out_status     (status)
  );

  assign out_tdata = {3'b000, status, granted_id};

endmodule

// ----- bench/fifo_free_list_id_allocator_unit_tb.sv -----
module fifo_free_list_id_allocator_unit_tb;
  import fflid_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int Q_DEPTH     = 4;

  typedef struct {
    logic                act;
    logic [REQ_ID_W-1:0] id;
  } id_req_t;

  typedef struct {
    logic            act;
    logic [ID_W-1:0] id;
    status_t         st;
  } grant_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic [15:0] in_tdata   = '0;
  logic        in_tuser   = ACT_ALLOC;
  logic        out_tready = 1'b0;
  logic        in_tready;
  logic        out_tvalid;
  logic [15:0] out_tdata;

  // predictor state
  logic [LINK_W-1:0] fl_link [POOL_DEPTH];
  bit                fl_mark [POOL_DEPTH];
  logic [LINK_W-1:0] fl_head;
  logic [LINK_W-1:0] fl_tail;

  id_req_t             req_q[$];
  grant_t              grants_due[$];
  logic [ID_W-1:0]     held_ids[$];
  bit                  in_acc = 1'b0;
  bit                  quiet  = 1'b0;
  int                  errs   = 0;
  int                  cyc    = 0;

  always #5 clk = ~clk;

  fifo_free_list_id_allocator_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  function automatic void pool_reset();
    for (int i = 0; i < POOL_DEPTH; i++) begin
      fl_link[i] = LINK_W'(i + 1);
      fl_mark[i] = 1'b1;
    end
    fl_head = '0;
    fl_tail = TAIL_INIT;
  endfunction

  function automatic void predict_grant(logic act, logic [REQ_ID_W-1:0] rid);
    grant_t g;
    g.act = act;
    g.id  = '0;
    g.st  = ST_OK;
    if (act == ACT_ALLOC) begin
      if (int'(fl_head) >= POOL_DEPTH) begin
        g.st = ST_EMPTY;
      end else begin
        if (fl_head == fl_tail) fl_tail = LINK_END;
        g.id = fl_head[ID_W-1:0];
        fl_mark[int'(fl_head)] = 1'b0;
        fl_head = fl_link[int'(fl_head)];
        if (fl_head > LINK_END) fl_head = LINK_END;
      end
    end else if (int'(rid) >= POOL_DEPTH) begin
      g.st = ST_RANGE;
    end else if (fl_mark[int'(rid)]) begin
      g.st = ST_FREE;
    end else begin
      fl_link[int'(rid)] = LINK_END;
      if (int'(fl_tail) >= POOL_DEPTH) fl_head = LINK_W'(rid);
      else fl_link[int'(fl_tail)] = LINK_W'(rid);
      fl_mark[int'(rid)] = 1'b1;
      fl_tail = LINK_W'(rid);
    end
    grants_due = {grants_due, g};
  endfunction

  task automatic queue_req(logic act, logic [REQ_ID_W-1:0] id);
    id_req_t r;
    while (req_q.size() >= Q_DEPTH) @(posedge clk);
    r.act = act;
    r.id  = id;
    req_q = {req_q, r};
  endtask

  function automatic logic [ID_W-1:0] take_held();
    int k;
    logic [ID_W-1:0] id;
    k  = $urandom_range(held_ids.size() - 1);
    id = held_ids[k];
    held_ids.delete(k);
    return id;
  endfunction

  // hold the sender until the block has drained, then resync the held list
  task automatic drain_wait();
    wait (req_q.size() == 0 && !in_tvalid && grants_due.size() == 0);
    @(posedge clk);
    held_ids.delete();
    for (int i = 0; i < POOL_DEPTH; i++)
      if (!fl_mark[i]) held_ids = {held_ids, ID_W'(i)};
  endtask

  always @(negedge clk) begin : drv
    id_req_t r;
    if (rst_n && (!in_tvalid || in_acc)) begin
      if (req_q.size() > 0 && (quiet || $urandom_range(99) >= 24)) begin
        r = req_q.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= {{(16 - REQ_ID_W){1'b0}}, r.id};
        in_tuser  <= r.act;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
    out_tready <= quiet || ($urandom_range(99) >= 24);
  end

  always @(posedge clk) begin : mon
    grant_t g;
    in_acc <= rst_n && in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready)
      predict_grant(in_tuser, in_tdata[REQ_ID_W-1:0]);
    if (rst_n && out_tvalid && out_tready) begin
      if (grants_due.size() == 0) begin
        errs++;
        if (errs <= 10) $display("unexpected result item: tdata %h", out_tdata);
      end else begin
        g = grants_due.pop_front();
        if (out_tdata[ID_W-1:0] !== g.id || out_tdata[12:11] !== g.st) begin
          errs++;
          if (errs <= 10)
            $display("mismatch: granted_id exp %0d got %0d, status exp %0d got %0d",
                     g.id, out_tdata[ID_W-1:0], g.st, out_tdata[12:11]);
        end
        if (g.act == ACT_ALLOC && g.st == ST_OK) held_ids = {held_ids, g.id};
      end
    end
  end

  always @(posedge clk) begin
    cyc++;
    if (cyc > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int n;
    pool_reset();
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // releases of ids that are still free, then allocs and releases, some double
    queue_req(ACT_RELEASE, 11'd0);
    queue_req(ACT_RELEASE, 11'h7FF);
    queue_req(ACT_RELEASE, 11'h555);
    queue_req(ACT_RELEASE, 11'h2AA);
    queue_req(ACT_ALLOC, '0);
    queue_req(ACT_ALLOC, '0);
    queue_req(ACT_ALLOC, '0);
    queue_req(ACT_RELEASE, 11'd1);
    queue_req(ACT_RELEASE, 11'd1);
    queue_req(ACT_RELEASE, 11'd0);
    queue_req(ACT_ALLOC, '0);
    queue_req(ACT_RELEASE, 11'd2);
    queue_req(ACT_ALLOC, '0);
    queue_req(ACT_RELEASE, 11'd3);
    queue_req(ACT_RELEASE, 11'h400);
    queue_req(ACT_ALLOC, '0);
    queue_req(ACT_ALLOC, '0);
    drain_wait();

    // empty the pool, then allocate past the end
    n = POOL_DEPTH - held_ids.size();
    quiet = 1'b1;
    repeat (n + 3) queue_req(ACT_ALLOC, '0);
    quiet = 1'b0;
    drain_wait();

    // release into an empty list and take it straight back
    queue_req(ACT_RELEASE, take_held());
    queue_req(ACT_ALLOC, '0);
    queue_req(ACT_ALLOC, '0);
    queue_req(ACT_RELEASE, take_held());
    queue_req(ACT_RELEASE, take_held());
    queue_req(ACT_ALLOC, '0);
    queue_req(ACT_ALLOC, '0);
    queue_req(ACT_ALLOC, '0);

    for (int k = 0; k < 650; k++) begin
      int roll;
      quiet = (k >= 200 && k < 350);
      roll  = $urandom_range(99);
      if (held_ids.size() > 0 && roll < 45)
        queue_req(ACT_RELEASE, take_held());
      else if (roll < 85)
        queue_req(ACT_ALLOC, REQ_ID_W'($urandom));
      else
        queue_req(ACT_RELEASE, REQ_ID_W'($urandom));
    end
    quiet = 1'b0;

    wait (req_q.size() == 0 && !in_tvalid && grants_due.size() == 0);
    repeat (20) @(posedge clk);
    if (errs == 0 && grants_due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
